FILE: hdl/be3_pkg.sv
// Shared types and constants for the 3x3 binary erosion unit.
`default_nettype none
package be3_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 1024;

   // column index into the line buffers
   localparam int COL_W = $clog2(MAX_WIDTH);
   // frame dimensions and the input row counter (runs one past the height during flush)
   localparam int DIM_W = 11;
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int MASK_W = 9;
   localparam int PIX_W = 8;

   localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(1);

   localparam logic [PIX_W-1:0] PIX_BACKGROUND = 8'd0;
   localparam logic [PIX_W-1:0] PIX_FOREGROUND = 8'd255;
   localparam logic [MASK_W-1:0] MASK_RESET = 9'h1FF;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_ELEMENT_MASK = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   // per-item control handed to the window stage
   typedef struct packed {
      logic zero_flag;
      logic interior;
   } win_ctl_type;

   // second stage of the pipe
   typedef struct packed {
      win_ctl_type ctl;
      logic emit;
      logic last;
      logic [COL_W-1:0] col;
   } stage_type;

endpackage
`default_nettype wire

FILE: hdl/be3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module be3_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hdl/be3_window.sv
// 3x3 zero-flag window and the masked erosion decision.
`default_nettype none
module be3_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire be3_pkg::win_ctl_type          ctl,
   input  wire logic                          top_flag,
   input  wire logic                          mid_flag,
   input  wire logic [be3_pkg::MASK_W-1:0]    element_mask,
   output logic      [be3_pkg::PIX_W-1:0]     eroded_value
);
   import be3_pkg::*;

   logic [MASK_W-1:0] window_ff;
   logic [MASK_W-1:0] window_in;

   // shift each row one cell toward bit 0, new column enters at the row's top bit
   assign window_in = {ctl.zero_flag, window_ff[8:7], mid_flag,
                       window_ff[5:4], top_flag, window_ff[2:1]};

   always_comb begin
      eroded_value = PIX_BACKGROUND;
      if (ctl.interior && ((window_in & element_mask) == '0)) begin
         eroded_value = PIX_FOREGROUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (advance) begin
         window_ff <= window_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/binary_erosion_3x3_unit.sv
// Top level of the streaming 3x3 binary erosion unit.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  req     | in  | tvalid/tready        | tdata: pixel_value, tuser: padding
//  rsp     | out | tvalid/tready        | tdata: eroded_value, tlast: frame_last
//  csr     | in  | APB psel/penable     | mask @0x0, width @0x4, height @0x8
//
//  One pixel per cycle sustained while rsp is not stalled. The pixel that completes a result is
//  registered in stage 1 with its line buffer read, then the window fills the output register.
//  Outputs trail inputs by one row plus one pixel; width+1 padding transfers flush a frame.
//  Reset is synchronous; line buffer contents are not cleared (stale reads only
//  reach border outputs). A stalled rsp holds one result while one more item is taken.
`default_nettype none
module binary_erosion_3x3_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] pixel_value
   input  wire logic        req_tuser,   // [0] padding
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] eroded_value
   output logic             rsp_tlast,   // frame_last
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import be3_pkg::*;

   // ---------------------------------------------------------------- config
   logic [MASK_W-1:0] mask_ff;
   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic              cfg_write;
   logic              geom_write;
   reg_index_type     cfg_index;
   logic [DIM_W-1:0]  cfg_dim;

   assign csr_pready = 1'b1;
   assign cfg_index = reg_index_type'(csr_paddr[3:2]);
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_dim = csr_pwdata[DIM_W-1:0];
   assign geom_write = cfg_write &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= MASK_RESET;
         width_ff  <= MAX_W_DIM;
         height_ff <= MAX_H_DIM;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_ELEMENT_MASK: begin
               mask_ff <= csr_pwdata[MASK_W-1:0];
            end
            REG_FRAME_WIDTH: begin
               // saturate into 1..MAX_WIDTH
               if (cfg_dim == '0) width_ff <= MIN_DIM;
               else if (cfg_dim > MAX_W_DIM) width_ff <= MAX_W_DIM;
               else width_ff <= cfg_dim;
            end
            REG_FRAME_HEIGHT: begin
               if (cfg_dim == '0) height_ff <= MIN_DIM;
               else if (cfg_dim > MAX_H_DIM) height_ff <= MAX_H_DIM;
               else height_ff <= cfg_dim;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (cfg_index)
         REG_ELEMENT_MASK: csr_prdata = 32'(mask_ff);
         REG_FRAME_WIDTH:  csr_prdata = 32'(width_ff);
         REG_FRAME_HEIGHT: csr_prdata = 32'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- handshake
   logic      s1_valid_ff;
   stage_type s1_ff;
   logic      s1_go;
   logic      rsp_valid_ff;
   logic      accept;

   // a valid stage 1 moves on unless it carries a result and the output register is full and rsp is not ready
   assign s1_go = s1_valid_ff && (!s1_ff.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept = req_tvalid && req_tready;

   // ---------------------------------------------------------------- stage 0: position
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [DIM_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;

   logic [COL_W-1:0] col;
   logic [DIM_W-1:0] col_p1;
   logic [DIM_W-1:0] ocol_p1;
   logic [DIM_W-1:0] orow_p1;
   stage_type        s0;

   always_comb begin
      col = in_col_ff;
      if ({1'b0, in_col_ff} >= width_ff) col = '0;

      // pixels past the frame's last row are flush items
      s0.ctl.zero_flag = (in_row_ff < height_ff) &&
                         (req_tuser || req_tdata == PIX_BACKGROUND);
      s0.emit = (in_row_ff > DIM_W'(1)) || (in_row_ff == DIM_W'(1) && col != '0);
      s0.col  = col;

      ocol_p1 = {1'b0, out_col_ff} + DIM_W'(1);
      orow_p1 = DIM_W'(out_row_ff) + DIM_W'(1);
      s0.ctl.interior = (out_row_ff != '0) && (orow_p1 < height_ff) &&
                        (out_col_ff != '0) && (ocol_p1 < width_ff);
      s0.last = (orow_p1 >= height_ff) && (ocol_p1 >= width_ff);

      col_p1 = {1'b0, col} + DIM_W'(1);
      if (col_p1 >= width_ff) begin
         in_col_in = '0;
         in_row_in = in_row_ff + DIM_W'(1);
      end else begin
         in_col_in = col_p1[COL_W-1:0];
         in_row_in = in_row_ff;
      end

      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (s0.emit) begin
         if (s0.last) begin
            // frame done: everything starts over
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (ocol_p1 >= width_ff) begin
            out_col_in = '0;
            out_row_in = out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = ocol_p1[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (accept) begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s0;
      end
   end

   // ---------------------------------------------------------------- line buffers
   // bit 1: older row flag, bit 0: newer row flag; both live at the column address
   logic [1:0] lb_rd_data;
   logic [1:0] lb_wr_data;

   // older <= newer, newer <= this pixel's flag
   assign lb_wr_data = {lb_rd_data[0], s1_ff.ctl.zero_flag};

   be3_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_ff.col),
      .wr_data (lb_wr_data),
      .rd_en   (accept),
      .rd_addr (s0.col),
      .rd_data (lb_rd_data)
   );

   // ---------------------------------------------------------------- stage 1: window
   logic [PIX_W-1:0] eroded_value;

   be3_window u_window (
      .clock        (clock),
      .reset        (reset),
      .advance      (s1_go),
      .ctl          (s1_ff.ctl),
      .top_flag     (lb_rd_data[1]),
      .mid_flag     (lb_rd_data[0]),
      .element_mask (mask_ff),
      .eroded_value (eroded_value)
   );

   // ---------------------------------------------------------------- output register
   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ff.emit) begin
         rsp_data_ff <= eroded_value;
         rsp_last_ff <= s1_ff.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
